// File: design/recurring_timer_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// recurring timer queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RECURRING_TIMER_QUEUE_UNIT_MACROS_SVH
`define RECURRING_TIMER_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define RTQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rtq_pkg.sv
// ----------------------------------------------------------------------------
// rtq_pkg
// shared constants and codes of the recurring timer queue
// ----------------------------------------------------------------------------
package rtq_pkg;

   localparam int MAX_TIMERS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT  = 32;

   localparam int ID_BITS    = 8;
   localparam int FIELD_BITS = 32;
   localparam int COUNT_BITS = 5;

   localparam logic [FIELD_BITS-1:0] RETRY_DELAY_RESET = 32'd5;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [1:0] OC_REMOVED = 2'd0;
   localparam logic [1:0] OC_NEXT    = 2'd1;
   localparam logic [1:0] OC_RETRY   = 2'd2;

endpackage

// File: design/rtq_req_if.sv
// ----------------------------------------------------------------------------
// rtq_req_if
// request channel of the recurring timer queue
// ----------------------------------------------------------------------------
interface rtq_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        operation;
   logic [rtq_pkg::ID_BITS-1:0]       timer_id;
   logic [rtq_pkg::FIELD_BITS-1:0]    fire_time;
   logic [rtq_pkg::FIELD_BITS-1:0]    repeat_period;
   logic [rtq_pkg::FIELD_BITS-1:0]    until_time;
   logic                              store_ok;

   modport source (output valid, output operation, output timer_id, output fire_time,
                   output repeat_period, output until_time, output store_ok, input ready);
   modport sink   (input valid, input operation, input timer_id, input fire_time,
                   input repeat_period, input until_time, input store_ok, output ready);
endinterface

// File: design/rtq_rsp_if.sv
// ----------------------------------------------------------------------------
// rtq_rsp_if
// response channel of the recurring timer queue
// ----------------------------------------------------------------------------
interface rtq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic                              fired;
   logic [rtq_pkg::ID_BITS-1:0]       fired_id;
   logic [rtq_pkg::FIELD_BITS-1:0]    fired_time;
   logic                              pushed;
   logic                              last_fire;
   logic [1:0]                        outcome;
   logic [rtq_pkg::COUNT_BITS-1:0]    active_count;

   modport source (output valid, output status, output fired, output fired_id,
                   output fired_time, output pushed, output last_fire, output outcome,
                   output active_count, input ready);
   modport sink   (input valid, input status, input fired, input fired_id,
                   input fired_time, input pushed, input last_fire, input outcome,
                   input active_count, output ready);
endinterface

// File: design/rtq_ram.sv
// ----------------------------------------------------------------------------
// rtq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/recurring_timer_queue_unit.sv
// add, cancel and a firing tick walk the entry ram one entry per cycle; op 3 does not
// throughput: one transaction at a time; the next is taken once the result is queued,
// and a result still held on the output stalls the done state
// reset: synchronous, clears the tick counter, the timer count and retry_delay to 5
// ----------------------------------------------------------------------------
// recurring_timer_queue_unit
// timer table sorted by deadline, held in a ram and walked by a sequencer
// ----------------------------------------------------------------------------
module recurring_timer_queue_unit #(
   parameter int MAX_TIMERS = rtq_pkg::MAX_TIMERS_DEFAULT,
   parameter int TIME_BITS  = rtq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rtq_pkg::FIELD_BITS-1:0] csr_wr_data,
   rtq_req_if.sink                        req_ch,
   rtq_rsp_if.source                      rsp_ch
);

   localparam int AW = $clog2(MAX_TIMERS);
   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int TB = TIME_BITS;

   typedef struct packed {
      logic [rtq_pkg::ID_BITS-1:0] id;
      logic [TB-1:0]               fire;
      logic [TB-1:0]               period;
      logic [TB-1:0]               end_tick;
      logic                        retry;
      logic [TB-1:0]               retry_due;
   } entry_type;

   typedef struct packed {
      logic [1:0]                        status;
      logic                              fired;
      logic [rtq_pkg::ID_BITS-1:0]       fired_id;
      logic [rtq_pkg::FIELD_BITS-1:0]    fired_time;
      logic                              pushed;
      logic                              last_fire;
      logic [1:0]                        outcome;
      logic [rtq_pkg::COUNT_BITS-1:0]    active_count;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE, S_HEAD, S_EVAL, S_SCAN, S_DECIDE, S_REMOVE, S_INSERT, S_DONE
   } state_type;

   function automatic logic [TB-1:0] due_of(entry_type e);
      return e.retry ? e.retry_due : e.fire;
   endfunction

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [TB-1:0]                  tick_ff, tick_in;
   logic [rtq_pkg::FIELD_BITS-1:0] retry_delay_ff, retry_delay_in;
   logic [1:0]                     op_ff, op_in;
   logic                           store_ok_ff, store_ok_in;
   entry_type                      rec_ff, rec_in;
   logic [CW-1:0]                  rd_idx_ff, rd_idx_in;
   logic                           chk_vld_ff, chk_vld_in;
   logic [CW-1:0]                  chk_idx_ff, chk_idx_in;
   logic                           found_ff, found_in;
   logic [CW-1:0]                  found_idx_ff, found_idx_in;
   logic [CW-1:0]                  pos_ff, pos_in;
   logic                           stop_ff, stop_in;
   logic                           reinsert_ff, reinsert_in;
   result_type                     res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   result_type                     rsp_data_ff, rsp_data_in;

   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   entry_type       ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   entry_type       ram_rd_data;

   logic            req_fire;
   logic            is_last;
   logic [TB:0]     next_sum;
   logic [TB:0]     retry_sum;

   rtq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_TIMERS)
   ) u_rtq_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);

   assign is_last   = (rec_ff.period != '0) && (rec_ff.end_tick != '0) &&
                      ((rec_ff.fire >= rec_ff.end_tick) ||
                       (rec_ff.period > (rec_ff.end_tick - rec_ff.fire)));
   assign next_sum  = {1'b0, rec_ff.fire} + {1'b0, rec_ff.period};
   assign retry_sum = {1'b0, tick_ff} + {1'b0, TB'(retry_delay_ff)};

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      tick_in        = tick_ff;
      retry_delay_in = retry_delay_ff;
      op_in          = op_ff;
      store_ok_in    = store_ok_ff;
      rec_in         = rec_ff;
      rd_idx_in      = rd_idx_ff;
      chk_vld_in     = chk_vld_ff;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      pos_in         = pos_ff;
      stop_in        = stop_ff;
      reinsert_in    = reinsert_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;

      if (csr_wr_en) begin
         retry_delay_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in            = req_ch.operation;
               store_ok_in      = req_ch.store_ok;
               rec_in.id        = req_ch.timer_id;
               rec_in.fire      = TB'(req_ch.fire_time);
               rec_in.period    = TB'(req_ch.repeat_period);
               rec_in.end_tick  = TB'(req_ch.until_time);
               rec_in.retry     = 1'b0;
               rec_in.retry_due = '0;
               res_in           = '0;
               rd_idx_in        = '0;
               chk_vld_in       = 1'b0;
               found_in         = 1'b0;
               pos_in           = '0;
               stop_in          = 1'b0;
               reinsert_in      = 1'b0;
               case (req_ch.operation) inside
                  rtq_pkg::OP_ADD, rtq_pkg::OP_CANCEL: begin
                     state_in = S_SCAN;
                  end
                  rtq_pkg::OP_TICK: begin
                     tick_in     = tick_ff + 1'b1;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = (count_ff == '0) ? S_DONE : S_HEAD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_HEAD: begin
            if (due_of(ram_rd_data) <= tick_ff) begin
               rec_in            = ram_rd_data;
               res_in.fired      = 1'b1;
               res_in.fired_id   = ram_rd_data.id;
               res_in.fired_time = rtq_pkg::FIELD_BITS'(ram_rd_data.fire);
               res_in.pushed     = !ram_rd_data.retry;
               state_in          = S_EVAL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EVAL: begin
            res_in.last_fire = is_last;
            if (!store_ok_ff) begin
               res_in.outcome   = rtq_pkg::OC_RETRY;
               rec_in.retry     = 1'b1;
               rec_in.retry_due = retry_sum[TB] ? '1 : retry_sum[TB-1:0];
               reinsert_in      = 1'b1;
            end else if ((rec_ff.period != '0) && !is_last) begin
               res_in.outcome   = rtq_pkg::OC_NEXT;
               rec_in.fire      = next_sum[TB] ? '1 : next_sum[TB-1:0];
               rec_in.retry     = 1'b0;
               rec_in.retry_due = '0;
               reinsert_in      = 1'b1;
            end else begin
               res_in.outcome = rtq_pkg::OC_REMOVED;
               reinsert_in    = 1'b0;
            end
            rd_idx_in  = CW'(1);
            chk_vld_in = 1'b0;
            state_in   = S_REMOVE;
         end
         S_SCAN: begin
            if (rd_idx_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
               chk_idx_in  = rd_idx_ff;
               chk_vld_in  = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               if ((ram_rd_data.id == rec_ff.id) && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = chk_idx_ff;
               end
               if (!stop_ff) begin
                  if (due_of(ram_rd_data) <= due_of(rec_ff)) begin
                     pos_in = chk_idx_ff + 1'b1;
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end
            if ((rd_idx_ff >= count_ff) && !chk_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rd_idx_in  = count_ff;
            chk_vld_in = 1'b0;
            case (op_ff)
               rtq_pkg::OP_ADD: begin
                  if (found_ff) begin
                     res_in.status = rtq_pkg::ST_DUPLICATE;
                     state_in      = S_DONE;
                  end else if (count_ff == CW'(MAX_TIMERS)) begin
                     res_in.status = rtq_pkg::ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_INSERT;
                  end
               end
               rtq_pkg::OP_CANCEL: begin
                  if (!found_ff) begin
                     res_in.status = rtq_pkg::ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     rd_idx_in = found_idx_ff + 1'b1;
                     state_in  = S_REMOVE;
                  end
               end
               default: begin
                  state_in = S_INSERT;
               end
            endcase
         end
         S_REMOVE: begin
            if (rd_idx_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
               chk_idx_in  = rd_idx_ff;
               chk_vld_in  = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(chk_idx_ff - 1'b1);
               ram_wr_data = ram_rd_data;
            end
            if ((rd_idx_ff >= count_ff) && !chk_vld_ff) begin
               count_in = count_ff - 1'b1;
               if ((op_ff == rtq_pkg::OP_TICK) && reinsert_ff) begin
                  rd_idx_in = '0;
                  found_in  = 1'b0;
                  pos_in    = '0;
                  stop_in   = 1'b0;
                  state_in  = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INSERT: begin
            if (rd_idx_ff > pos_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(rd_idx_ff - 1'b1);
               rd_idx_in   = rd_idx_ff - 1'b1;
               chk_idx_in  = rd_idx_ff - 1'b1;
               chk_vld_in  = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(chk_idx_ff + 1'b1);
               ram_wr_data = ram_rd_data;
            end
            if (!(rd_idx_ff > pos_ff) && !chk_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[AW-1:0];
               ram_wr_data = rec_ff;
               count_in    = count_ff + 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = res_ff;
               rsp_data_in.active_count = rtq_pkg::COUNT_BITS'(count_ff);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         tick_ff        <= '0;
         retry_delay_ff <= rtq_pkg::RETRY_DELAY_RESET;
         chk_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         tick_ff        <= tick_in;
         retry_delay_ff <= retry_delay_in;
         chk_vld_ff     <= chk_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff        <= op_in;
      store_ok_ff  <= store_ok_in;
      rec_ff       <= rec_in;
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      pos_ff       <= pos_in;
      stop_ff      <= stop_in;
      reinsert_ff  <= reinsert_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_data_ff.status;
   assign rsp_ch.fired        = rsp_data_ff.fired;
   assign rsp_ch.fired_id     = rsp_data_ff.fired_id;
   assign rsp_ch.fired_time   = rsp_data_ff.fired_time;
   assign rsp_ch.pushed       = rsp_data_ff.pushed;
   assign rsp_ch.last_fire    = rsp_data_ff.last_fire;
   assign rsp_ch.outcome      = rsp_data_ff.outcome;
   assign rsp_ch.active_count = rsp_data_ff.active_count;

endmodule

// File: design/rtq_checker.sv
// ----------------------------------------------------------------------------
// rtq_checker
// port level checks of the recurring timer queue, bound to the top level
// ----------------------------------------------------------------------------
`include "recurring_timer_queue_unit_macros.svh"

module rtq_checker #(
   parameter int MAX_TIMERS = rtq_pkg::MAX_TIMERS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic                              rsp_fired,
   input logic [rtq_pkg::ID_BITS-1:0]       rsp_fired_id,
   input logic                              rsp_pushed,
   input logic                              rsp_last_fire,
   input logic [1:0]                        rsp_outcome,
   input logic [rtq_pkg::COUNT_BITS-1:0]    rsp_active_count
);

   `RTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")
   `RTQ_ASSERT_IMPLIES(a_count_max, rsp_valid, (MAX_TIMERS > 31) || (int'(rsp_active_count) <= MAX_TIMERS), "active count above table size")
   `RTQ_ASSERT_IMPLIES(a_idle_fields, rsp_valid && !rsp_fired, (rsp_fired_id == '0) && !rsp_pushed && !rsp_last_fire && (rsp_outcome == rtq_pkg::OC_REMOVED), "service fields set without a fire")
   `RTQ_ASSERT_IMPLIES(a_status_nofire, rsp_valid && (rsp_status != rtq_pkg::ST_OK), !rsp_fired, "fire reported with error status")

endmodule

bind recurring_timer_queue_unit rtq_checker #(
   .MAX_TIMERS (MAX_TIMERS)
) u_rtq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_fired        (rsp_ch.fired),
   .rsp_fired_id     (rsp_ch.fired_id),
   .rsp_pushed       (rsp_ch.pushed),
   .rsp_last_fire    (rsp_ch.last_fire),
   .rsp_outcome      (rsp_ch.outcome),
   .rsp_active_count (rsp_ch.active_count)
);

// File: verif/rtq_tb_if.sv
// ----------------------------------------------------------------------------
// rtq_tb_if
// transaction types of the testbench, which reuses the block's channel interfaces
// ----------------------------------------------------------------------------
package rtq_tb_pkg;

   typedef struct packed {
      logic [1:0]                     operation;
      logic [rtq_pkg::ID_BITS-1:0]    timer_id;
      logic [rtq_pkg::FIELD_BITS-1:0] fire_time;
      logic [rtq_pkg::FIELD_BITS-1:0] repeat_period;
      logic [rtq_pkg::FIELD_BITS-1:0] until_time;
      logic                           store_ok;
   } timer_req_type;

   typedef struct packed {
      logic [1:0]                     status;
      logic                           fired;
      logic [rtq_pkg::ID_BITS-1:0]    fired_id;
      logic [rtq_pkg::FIELD_BITS-1:0] fired_time;
      logic                           pushed;
      logic                           last_fire;
      logic [1:0]                     outcome;
      logic [rtq_pkg::COUNT_BITS-1:0] active_count;
   } timer_rsp_type;

endpackage

// File: verif/recurring_timer_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// recurring_timer_queue_unit_tb
// drives adds, cancels, ticks and unused ops with random idling and backpressure, predicts
// every response with a sorted timer table of its own and compares each field
// ----------------------------------------------------------------------------
module recurring_timer_queue_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = rtq_pkg::MAX_TIMERS_DEFAULT;
   localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

   typedef struct {
      logic [7:0]  id;
      logic [31:0] fire;
      logic [31:0] period;
      logic [31:0] until_t;
      logic        retry;
      logic [31:0] retry_due;
   } timer_ent_type;

   typedef struct {
      rtq_tb_pkg::timer_req_type req;
      logic                      known;
      rtq_tb_pkg::timer_rsp_type rsp;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [31:0] csr_wr_data = '0;

   rtq_req_if req_ch ();
   rtq_rsp_if rsp_ch ();

   recurring_timer_queue_unit i_dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   timer_ent_type timer_table[$];
   logic [31:0] now_tick;
   logic [31:0] retry_delay;
   rtq_tb_pkg::timer_rsp_type expected_rsps[$];
   int error_count = 0;
   bit hold_start = 0;
   bit hold_active = 0;
   bit ids_small = 1;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // long receiver hold-off, counted here
   initial begin
      wait (hold_start);
      hold_active <= 1;
      repeat (300) @(posedge clock);
      hold_active <= 0;
   end

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? TMAX : s[31:0];
   endfunction

   function automatic logic [31:0] deadline_of(timer_ent_type e);
      return e.retry ? e.retry_due : e.fire;
   endfunction

   function automatic void insert_timer(timer_ent_type e);
      int pos;
      pos = 0;
      while (pos < timer_table.size() && deadline_of(timer_table[pos]) <= deadline_of(e))
         pos++;
      timer_table.insert(pos, e);
   endfunction

   function automatic int find_timer(logic [7:0] id);
      foreach (timer_table[i])
         if (timer_table[i].id == id) return i;
      return -1;
   endfunction

   function automatic rtq_tb_pkg::timer_rsp_type predict_timer_rsp(
      rtq_tb_pkg::timer_req_type r);
      rtq_tb_pkg::timer_rsp_type o;
      timer_ent_type e;
      logic is_last;
      int p;
      o = '0;
      case (r.operation)
         rtq_pkg::OP_ADD: begin
            if (find_timer(r.timer_id) >= 0) o.status = rtq_pkg::ST_DUPLICATE;
            else if (timer_table.size() >= NT) o.status = rtq_pkg::ST_FULL;
            else begin
               e.id = r.timer_id; e.fire = r.fire_time; e.period = r.repeat_period;
               e.until_t = r.until_time; e.retry = 0; e.retry_due = '0;
               insert_timer(e);
            end
         end
         rtq_pkg::OP_CANCEL: begin
            p = find_timer(r.timer_id);
            if (p < 0) o.status = rtq_pkg::ST_NOT_FOUND;
            else timer_table.delete(p);
         end
         rtq_pkg::OP_TICK: begin
            now_tick = now_tick + 32'd1;
            if (timer_table.size() > 0 && deadline_of(timer_table[0]) <= now_tick) begin
               e = timer_table.pop_front();
               is_last = e.period != 0 && e.until_t != 0 &&
                         (e.fire >= e.until_t || e.period > e.until_t - e.fire);
               o.fired = 1; o.fired_id = e.id; o.fired_time = e.fire;
               o.pushed = !e.retry; o.last_fire = is_last;
               if (!r.store_ok) begin
                  o.outcome = rtq_pkg::OC_RETRY;
                  e.retry = 1; e.retry_due = sat_sum(now_tick, retry_delay);
                  insert_timer(e);
               end else if (e.period != 0 && !is_last) begin
                  o.outcome = rtq_pkg::OC_NEXT;
                  e.fire = sat_sum(e.fire, e.period); e.retry = 0; e.retry_due = '0;
                  insert_timer(e);
               end else o.outcome = rtq_pkg::OC_REMOVED;
            end
         end
         default: ;
      endcase
      o.active_count = rtq_pkg::COUNT_BITS'(timer_table.size());
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   task automatic send_item(rtq_tb_pkg::timer_req_type r, logic known,
                            rtq_tb_pkg::timer_rsp_type k);
      rtq_tb_pkg::timer_rsp_type p;
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      p = predict_timer_rsp(r);
      if (known && p != k) report_mismatch("directed row", 32'(p.status), 32'(k.status));
      expected_rsps.push_back(p);
      req_ch.valid <= 1;
      req_ch.operation <= r.operation; req_ch.timer_id <= r.timer_id;
      req_ch.fire_time <= r.fire_time; req_ch.repeat_period <= r.repeat_period;
      req_ch.until_time <= r.until_time; req_ch.store_ok <= r.store_ok;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_ch.valid <= 0;
      while (expected_rsps.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic write_retry_delay(logic [31:0] v);
      wait_drained();
      csr_wr_en <= 1; csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      retry_delay = v;
   endtask

   function automatic rtq_tb_pkg::timer_req_type make_req(logic [1:0] op, logic [7:0] id,
                                                          logic [31:0] f, logic [31:0] per,
                                                          logic [31:0] un, logic ok);
      rtq_tb_pkg::timer_req_type r;
      r.operation = op; r.timer_id = id; r.fire_time = f;
      r.repeat_period = per; r.until_time = un; r.store_ok = ok;
      return r;
   endfunction

   function automatic rtq_tb_pkg::timer_req_type random_req();
      logic [31:0] near;
      int k;
      near = now_tick + $urandom_range(0, 12);
      k = $urandom_range(0, 99);
      if (k < 35)
         return make_req(rtq_pkg::OP_ADD,
                         ids_small ? 8'($urandom_range(0, 23)) : 8'($urandom),
                         ($urandom_range(0, 19) == 0) ? $urandom : near,
                         ($urandom_range(0, 2) == 0) ? 32'd0 :
                            (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 6)),
                         ($urandom_range(0, 1) == 0) ? 32'd0 :
                            (($urandom_range(0, 19) == 0) ? $urandom :
                             near + $urandom_range(0, 20)),
                         1'($urandom));
      else if (k < 45)
         return make_req(rtq_pkg::OP_CANCEL,
                         ids_small ? 8'($urandom_range(0, 23)) : 8'($urandom),
                         $urandom, $urandom, $urandom, 1'($urandom));
      else if (k < 47)
         return make_req(rtq_pkg::OP_NONE, 8'($urandom), $urandom, $urandom, $urandom,
                         1'($urandom));
      return make_req(rtq_pkg::OP_TICK, 8'($urandom), $urandom, $urandom, $urandom,
                      $urandom_range(0, 3) != 0);
   endfunction

   // response side: random stalls plus one long hold-off
   initial begin
      rtq_tb_pkg::timer_rsp_type exp_rsp, got;
      rsp_ch.ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_active) rsp_ch.ready <= 0;
         else rsp_ch.ready <= ($urandom_range(0, 5) == 0) ? 1'b0 : 1'b1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.status, rsp_ch.fired, rsp_ch.fired_id, rsp_ch.fired_time,
                   rsp_ch.pushed, rsp_ch.last_fire, rsp_ch.outcome, rsp_ch.active_count};
            if (expected_rsps.size() == 0)
               report_mismatch("unexpected transaction", 32'd0, 32'd0);
            else begin
               exp_rsp = expected_rsps.pop_front();
               if (got.status !== exp_rsp.status)
                  report_mismatch("status", 32'(got.status), 32'(exp_rsp.status));
               if (got.fired !== exp_rsp.fired)
                  report_mismatch("fired", 32'(got.fired), 32'(exp_rsp.fired));
               if (got.fired_id !== exp_rsp.fired_id)
                  report_mismatch("fired_id", 32'(got.fired_id), 32'(exp_rsp.fired_id));
               if (got.fired_time !== exp_rsp.fired_time)
                  report_mismatch("fired_time", got.fired_time, exp_rsp.fired_time);
               if (got.pushed !== exp_rsp.pushed)
                  report_mismatch("pushed", 32'(got.pushed), 32'(exp_rsp.pushed));
               if (got.last_fire !== exp_rsp.last_fire)
                  report_mismatch("last_fire", 32'(got.last_fire), 32'(exp_rsp.last_fire));
               if (got.outcome !== exp_rsp.outcome)
                  report_mismatch("outcome", 32'(got.outcome), 32'(exp_rsp.outcome));
               if (got.active_count !== exp_rsp.active_count)
                  report_mismatch("active_count", 32'(got.active_count),
                                  32'(exp_rsp.active_count));
            end
         end
      end
   end

   initial begin
      dir_row_type rows[$];
      rtq_tb_pkg::timer_rsp_type z;
      logic [31:0] delays[4];
      req_ch.valid <= 0; req_ch.operation <= rtq_pkg::OP_TICK; req_ch.timer_id <= '0;
      req_ch.fire_time <= '0; req_ch.repeat_period <= '0; req_ch.until_time <= '0;
      req_ch.store_ok <= 0;
      now_tick = '0; retry_delay = rtq_pkg::RETRY_DELAY_RESET;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      z = '0;
      // empty table: tick, unknown cancel, unused op
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b1, z});
      z.status = rtq_pkg::ST_NOT_FOUND;
      rows.push_back('{make_req(rtq_pkg::OP_CANCEL, 8'hFF, 32'd0, 32'd0, 32'd0, 1'b0),
                       1'b1, z});
      z = '0;
      rows.push_back('{make_req(rtq_pkg::OP_NONE, 8'hFF, TMAX, TMAX, TMAX, 1'b1), 1'b1, z});
      z.active_count = 5'd1;
      rows.push_back('{make_req(rtq_pkg::OP_ADD, 8'hFF, TMAX, TMAX, TMAX, 1'b1), 1'b1, z});
      z.status = rtq_pkg::ST_DUPLICATE;
      rows.push_back('{make_req(rtq_pkg::OP_ADD, 8'hFF, 32'd0, 32'd0, 32'd0, 1'b0), 1'b1, z});
      rows.push_back('{make_req(rtq_pkg::OP_ADD, 8'h00, 32'd2, 32'd3, 32'd8, 1'b0), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_ADD, 8'h01, 32'd2, 32'd0, 32'd0, 1'b1), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_ADD, 8'h02, 32'd3, TMAX, 32'd0, 1'b1), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_CANCEL, 8'hFF, 32'd0, 32'd0, 32'd0, 1'b1),
                       1'b0, z});
      rows.push_back('{make_req(rtq_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b0, z});
      foreach (rows[i]) send_item(rows[i].req, rows[i].known, rows[i].rsp);

      // fill beyond capacity for full and duplicate-before-full
      for (int i = 0; i < 18; i++)
         send_item(make_req(rtq_pkg::OP_ADD, 8'(i + 16), $urandom_range(0, 40), 32'd0, 32'd0,
                            1'b1), 1'b0, z);
      send_item(make_req(rtq_pkg::OP_ADD, 8'd16, 32'd0, 32'd0, 32'd0, 1'b1), 1'b0, z);

      // long hold-off on the response side while requests keep coming
      hold_start = 1;
      for (int i = 0; i < 12; i++) send_item(random_req(), 1'b0, z);
      for (int i = 0; i < 20; i++)
         send_item(make_req(rtq_pkg::OP_CANCEL, 8'(i + 10), 32'd0, 32'd0, 32'd0, 1'b1),
                   1'b0, z);

      delays[0] = 32'd0; delays[1] = TMAX; delays[2] = 32'd1; delays[3] = 32'd3;
      for (int ph = 0; ph < 4; ph++) begin
         write_retry_delay(delays[ph]);
         ids_small = (ph != 1);
         for (int i = 0; i < 100; i++) send_item(random_req(), 1'b0, z);
      end

      wait_drained();
      if (expected_rsps.size() != 0) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (error_count == 0) begin
         $display("Testbench completed without errors");
         $finish;
      end else begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
